@@ design/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define SSCR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Same, written as an antecedent and a next-cycle consequent.
`define SSCR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) ante |=> cons) \
        else $error(msg);

`endif

@@ design/sscr_pkg.sv @@
package sscr_pkg;

    // Field and register widths
    localparam int PULSE_BITS = 32;
    localparam int CMD_W      = 8;
    localparam int STEP_W     = 16;
    localparam int CLK_W      = 32;
    localparam int NUM_W      = 40;
    localparam int FREQ_W     = 24;
    localparam int CFG_W      = NUM_W;
    localparam int CFG_IDX_W  = 3;

    // Shared divider: numerator of final load is 2*N + m, divisor up to 2*freq
    localparam int DVD_W  = NUM_W + 2;
    localparam int DVS_W  = FREQ_W + 1;
    localparam int DCNT_W = $clog2(DVD_W + 1);

    localparam logic [CMD_W-1:0]  PING_BYTE = '1;
    localparam logic [FREQ_W-1:0] FREQ_MAX  = '1;

    // Register reset values
    localparam logic [CMD_W-1:0]  MAX_CMD_RST   = 8'd254;
    localparam logic [CMD_W-1:0]  MIN_CMD_RST   = 8'd0;
    localparam logic [CMD_W-1:0]  OFFSET_RST    = 8'd127;
    localparam logic [STEP_W-1:0] FREQ_STEP_RST = 16'd100;
    localparam logic [CLK_W-1:0]  CNT_CLK_RST   = 32'd1000000;
    localparam logic [NUM_W-1:0]  FINAL_NUM_RST = 40'd1000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_CMD,
        CFG_MIN_CMD,
        CFG_OFFSET,
        CFG_FREQ_STEP,
        CFG_CNT_CLK,
        CFG_FINAL_NUM
    } t_cfg_idx;

    // Microcode
    localparam int PC_W = 3;
    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_DISPATCH,
        OP_FREQ,
        OP_LD_STEP,
        OP_LD_FIN,
        OP_DIV,
        OP_STORE,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        J_NEXT,
        J_GOTO,
        J_IN_VALID,
        J_DISPATCH,
        J_DIV_DONE,
        J_OUT_FREE
    } t_jmp;

    typedef struct packed {
        t_op  op;
        t_jmp jmp;
        t_pc  target;
    } t_uword;

    localparam t_pc PC_IDLE     = 3'd0;
    localparam t_pc PC_DISPATCH = 3'd1;
    localparam t_pc PC_FREQ     = 3'd2;
    localparam t_pc PC_LD_STEP  = 3'd3;
    localparam t_pc PC_LD_FIN   = 3'd4;
    localparam t_pc PC_DIV      = 3'd5;
    localparam t_pc PC_STORE    = 3'd6;
    localparam t_pc PC_EMIT     = 3'd7;

    // Control store: one word per step
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        unique case (pc)
            PC_IDLE:     w = '{op: OP_WAIT,     jmp: J_IN_VALID, target: PC_DISPATCH};
            PC_DISPATCH: w = '{op: OP_DISPATCH, jmp: J_DISPATCH, target: PC_EMIT};
            PC_FREQ:     w = '{op: OP_FREQ,     jmp: J_NEXT,     target: PC_LD_STEP};
            PC_LD_STEP:  w = '{op: OP_LD_STEP,  jmp: J_GOTO,     target: PC_DIV};
            PC_LD_FIN:   w = '{op: OP_LD_FIN,   jmp: J_NEXT,     target: PC_DIV};
            PC_DIV:      w = '{op: OP_DIV,      jmp: J_DIV_DONE, target: PC_STORE};
            PC_STORE:    w = '{op: OP_STORE,    jmp: J_NEXT,     target: PC_EMIT};
            PC_EMIT:     w = '{op: OP_EMIT,     jmp: J_OUT_FREE, target: PC_IDLE};
            default:     w = '{op: OP_WAIT,     jmp: J_GOTO,     target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ design/sscr_div.sv @@
module sscr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sscr_pkg::DVD_W-1:0]  i_dividend,
    input  logic [sscr_pkg::DVS_W-1:0]  i_divisor,
    output logic                        o_busy,
    output logic [sscr_pkg::DVD_W-1:0]  o_quot
);
    import sscr_pkg::*;

    logic [DCNT_W-1:0] r_cnt;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVD_W-1:0]  r_q;

    logic [DVS_W:0]    w_sh;
    logic [DVS_W:0]    w_diff;
    logic              w_fits;

    // One restoring step: shift in the next dividend bit, try a subtract
    assign w_sh   = {r_rem, r_q[DVD_W-1]};
    assign w_diff = w_sh - {1'b0, r_dvs};
    assign w_fits = !w_diff[DVS_W];

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_q;

    // Iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DCNT_W'(DVD_W);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_q   <= i_dividend;
        end else if (o_busy) begin
            r_rem <= w_fits ? w_diff[DVS_W-1:0] : w_sh[DVS_W-1:0];
            r_q   <= {r_q[DVD_W-2:0], w_fits};
        end
    end

endmodule

@@ design/stepper_speed_command_ramp.sv @@
// Stepper speed command with linear frequency ramp. One transaction in gives
// exactly one transaction out. A command byte (mode 0) pings on 255, is
// rejected when out of [min_command, max_command] or while a ramp is pending,
// or sets direction and target magnitude (distance of the byte from the
// zero-speed code) and, if the magnitude changes, queues one ramp tick per
// unit of speed change plus one final tick. Each ramp tick (mode 1) steps the
// frequency by freq_step and loads counter_clock / (2 * frequency); the final
// tick loads round(final_numerator / magnitude). Zero divisors load 0, results
// saturate at the pulse width. The block takes one item at a time. Commands
// and idle ticks go from dispatch to emit; ramp ticks step the frequency,
// then run the shared one-bit-per-cycle divider (42 iterations) and store
// its result before emit; final ticks skip the frequency step. The next
// transaction can be taken in the cycle after the result is registered; a
// result is only registered while the output register is empty or being
// read, so output stalls hold off the input. Configuration must be written
// through i_cfg_we only while idle (not enforced here); takes effect at once.
module stepper_speed_command_ramp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [sscr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sscr_pkg::CFG_W-1:0]       i_cfg_data,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_mode,
    input  logic [sscr_pkg::CMD_W-1:0]       i_command_byte,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [sscr_pkg::PULSE_BITS-1:0]  o_pulse_value,
    output logic                             o_pulse_updated,
    output logic                             o_direction_level,
    output logic                             o_motor_enabled,
    output logic                             o_ping_reply,
    output logic                             o_command_rejected,
    output logic                             o_ramping
);
    import sscr_pkg::*;

    // Configuration registers
    logic [CMD_W-1:0]  r_max_cmd;
    logic [CMD_W-1:0]  r_min_cmd;
    logic [CMD_W-1:0]  r_offset;
    logic [STEP_W-1:0] r_fstep;
    logic [CLK_W-1:0]  r_cclk;
    logic [NUM_W-1:0]  r_fnum;

    // Motion state
    logic [CMD_W-1:0]  r_mag;
    logic [FREQ_W-1:0] r_freq;
    logic [CMD_W-1:0]  r_steps;
    logic              r_up;
    logic              r_fin;
    logic              r_dir;
    logic              r_en;
    logic [PULSE_BITS-1:0] r_cmp;

    // Sequencer and per-item flags
    t_pc               r_pc;
    t_pc               n_pc;
    t_uword            w_uw;
    logic              r_mode;
    logic [CMD_W-1:0]  r_cmd;
    logic              r_upd;
    logic              r_ping;
    logic              r_rej;
    logic              r_zero;

    // Output register
    logic              r_out_valid;
    logic [PULSE_BITS-1:0] r_o_pulse;
    logic              r_o_upd;
    logic              r_o_dir;
    logic              r_o_en;
    logic              r_o_ping;
    logic              r_o_rej;
    logic              r_o_ramp;

    // Datapath nets
    logic              w_busy;
    logic              w_out_free;
    logic              w_below;
    logic [CMD_W-1:0]  w_mag;
    logic              w_range_bad;
    logic [FREQ_W:0]   w_fsum;
    logic [FREQ_W-1:0] w_fstep_ext;
    logic [FREQ_W-1:0] w_freq_next;
    logic              w_div_start;
    logic              w_div_busy;
    logic [DVD_W-1:0]  w_dividend;
    logic [DVS_W-1:0]  w_divisor;
    logic [DVD_W-1:0]  w_quot;
    logic [PULSE_BITS-1:0] w_clamped;

    assign w_uw       = ucode(r_pc);
    assign w_busy     = (r_steps != '0) || r_fin;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (w_uw.op == OP_WAIT);

    // Command decode
    assign w_below     = (r_cmd < r_offset);
    assign w_mag       = w_below ? (r_offset - r_cmd) : (r_cmd - r_offset);
    assign w_range_bad = (r_cmd > r_max_cmd) || (r_cmd < r_min_cmd);

    // Saturating frequency step
    assign w_fstep_ext = FREQ_W'(r_fstep);
    assign w_fsum      = {1'b0, r_freq} + {1'b0, w_fstep_ext};
    always_comb begin
        if (r_up) begin
            w_freq_next = w_fsum[FREQ_W] ? FREQ_MAX : w_fsum[FREQ_W-1:0];
        end else begin
            w_freq_next = (r_freq < w_fstep_ext) ? '0 : (r_freq - w_fstep_ext);
        end
    end

    // Divider operands: ramp step or final rounded load
    assign w_div_start = (w_uw.op == OP_LD_STEP) || (w_uw.op == OP_LD_FIN);
    always_comb begin
        if (w_uw.op == OP_LD_FIN) begin
            w_dividend = DVD_W'({r_fnum, 1'b0}) + DVD_W'(r_mag);
            w_divisor  = DVS_W'({r_mag, 1'b0});
        end else begin
            w_dividend = DVD_W'(r_cclk);
            w_divisor  = {r_freq, 1'b0};
        end
    end

    sscr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot)
    );

    assign w_clamped = (|w_quot[DVD_W-1:PULSE_BITS]) ? '1 : w_quot[PULSE_BITS-1:0];

    // Step counter and conditional jumps
    always_comb begin
        case (w_uw.jmp)
            J_NEXT:     n_pc = r_pc + 1'b1;
            J_GOTO:     n_pc = w_uw.target;
            J_IN_VALID: n_pc = i_in_valid ? w_uw.target : r_pc;
            J_DISPATCH: begin
                if (r_mode && (r_steps != '0)) begin
                    n_pc = PC_FREQ;
                end else if (r_mode && r_fin) begin
                    n_pc = PC_LD_FIN;
                end else begin
                    n_pc = w_uw.target;
                end
            end
            J_DIV_DONE: n_pc = w_div_busy ? r_pc : w_uw.target;
            J_OUT_FREE: n_pc = w_out_free ? w_uw.target : r_pc;
            default:    n_pc = PC_IDLE;
        endcase
    end

    // Control and motion state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_cmd   <= MAX_CMD_RST;
            r_min_cmd   <= MIN_CMD_RST;
            r_offset    <= OFFSET_RST;
            r_fstep     <= FREQ_STEP_RST;
            r_cclk      <= CNT_CLK_RST;
            r_fnum      <= FINAL_NUM_RST;
            r_mag       <= '0;
            r_freq      <= '0;
            r_steps     <= '0;
            r_up        <= 1'b0;
            r_fin       <= 1'b0;
            r_dir       <= 1'b1;
            r_en        <= 1'b0;
            r_cmp       <= '0;
            r_pc        <= PC_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_CMD:   r_max_cmd <= i_cfg_data[CMD_W-1:0];
                    CFG_MIN_CMD:   r_min_cmd <= i_cfg_data[CMD_W-1:0];
                    CFG_OFFSET:    r_offset  <= i_cfg_data[CMD_W-1:0];
                    CFG_FREQ_STEP: r_fstep   <= i_cfg_data[STEP_W-1:0];
                    CFG_CNT_CLK:   r_cclk    <= i_cfg_data[CLK_W-1:0];
                    CFG_FINAL_NUM: r_fnum    <= i_cfg_data[NUM_W-1:0];
                    default: ;
                endcase
            end

            // Result register: load on emit, clear when taken
            if ((w_uw.op == OP_EMIT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (w_uw.op)
                OP_DISPATCH: begin
                    // accepted speed command: direction, magnitude, ramp setup
                    if (!r_mode && !w_busy && (r_cmd != PING_BYTE) && !w_range_bad) begin
                        if (w_below) begin
                            r_dir <= 1'b0;
                        end else if (w_mag != '0) begin
                            r_dir <= 1'b1;
                        end
                        if (w_mag > r_mag) begin
                            r_en    <= 1'b1;
                            r_up    <= 1'b1;
                            r_steps <= w_mag - r_mag;
                            r_fin   <= 1'b1;
                        end else if (w_mag < r_mag) begin
                            r_up    <= 1'b0;
                            r_steps <= r_mag - w_mag;
                            r_fin   <= 1'b1;
                        end
                        r_mag <= w_mag;
                    end
                end
                OP_FREQ: r_freq <= w_freq_next;
                OP_LD_STEP: r_steps <= r_steps - 1'b1;
                OP_LD_FIN: begin
                    if (!r_up && (r_mag == '0)) begin
                        r_en <= 1'b0;
                    end
                    r_fin <= 1'b0;
                end
                OP_STORE: r_cmp <= r_zero ? '0 : w_clamped;
                default: ;
            endcase
        end
    end

    // Item payload, flags and output data
    always_ff @(posedge i_clk) begin
        case (w_uw.op)
            OP_WAIT: begin
                if (i_in_valid) begin
                    r_mode <= i_mode;
                    r_cmd  <= i_command_byte;
                end
            end
            OP_DISPATCH: begin
                r_upd  <= 1'b0;
                r_ping <= !r_mode && !w_busy && (r_cmd == PING_BYTE);
                r_rej  <= !r_mode && (w_busy || ((r_cmd != PING_BYTE) && w_range_bad));
            end
            OP_LD_STEP: r_zero <= (r_freq == '0);
            OP_LD_FIN:  r_zero <= (r_mag == '0);
            OP_STORE:   r_upd  <= 1'b1;
            OP_EMIT: begin
                if (w_out_free) begin
                    r_o_pulse <= r_cmp;
                    r_o_upd   <= r_upd;
                    r_o_dir   <= r_dir;
                    r_o_en    <= r_en;
                    r_o_ping  <= r_ping;
                    r_o_rej   <= r_rej;
                    r_o_ramp  <= w_busy;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid        = r_out_valid;
    assign o_pulse_value      = r_o_pulse;
    assign o_pulse_updated    = r_o_upd;
    assign o_direction_level  = r_o_dir;
    assign o_motor_enabled    = r_o_en;
    assign o_ping_reply       = r_o_ping;
    assign o_command_rejected = r_o_rej;
    assign o_ramping          = r_o_ramp;

endmodule

@@ design/sscr_checker.sv @@
`include "assert_macros.svh"

module sscr_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             o_in_ready,
    input  logic                             o_out_valid,
    input  logic                             i_out_ready,
    input  logic [sscr_pkg::PULSE_BITS-1:0]  o_pulse_value,
    input  logic                             o_pulse_updated,
    input  logic                             o_ping_reply,
    input  logic                             o_command_rejected
);
    import sscr_pkg::*;

    logic w_in_acc;
    assign w_in_acc = i_in_valid && o_in_ready;

    // one transaction in flight: input closes right after acceptance
    `SSCR_ASSERT_NEXT(a_one_in_flight, w_in_acc, !o_in_ready, "second item taken while busy")

    // a ping reply is never also a rejection
    `SSCR_ASSERT(a_ping_not_rej, o_out_valid |-> !(o_ping_reply && o_command_rejected), "ping and reject together")

    // compare loads only come from ticks, which never ping or reject
    `SSCR_ASSERT(a_upd_is_tick, (o_out_valid && o_pulse_updated) |-> !(o_ping_reply || o_command_rejected), "load flagged on a command")

    // stalled result holds
    `SSCR_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_pulse_value), "stalled result changed")

endmodule

bind stepper_speed_command_ramp sscr_checker u_sscr_checker (.*);

@@ sim/stepper_speed_command_ramp_test.sv @@
`timescale 1ns / 100ps

module stepper_speed_command_ramp_test;

    import sscr_pkg::*;

    localparam int RAND_PHASES  = 6;
    localparam int PHASE_ITEMS  = 60;
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_WAIT  = 60;
    localparam int SHOW_LIMIT   = 10;

    // One output transaction, fields in port order
    typedef struct packed {
        logic [PULSE_BITS-1:0] pulse;
        logic                  upd;
        logic                  dir;
        logic                  en;
        logic                  ping;
        logic                  rej;
        logic                  busy;
    } t_ramp_result;

    typedef enum bit {ROW_ITEM, ROW_CFG} t_row_kind;

    // Directed stimulus row: either an input transaction or a register write
    typedef struct packed {
        t_row_kind        kind;
        logic             mode;
        logic [CMD_W-1:0] cmd;
        t_cfg_idx         idx;
        logic [CFG_W-1:0] data;
        bit               typed;
        t_ramp_result     shown;
    } t_script_row;

    // DUT ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_mode = 1'b0;
    logic [CMD_W-1:0]      i_command_byte = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [PULSE_BITS-1:0] o_pulse_value;
    logic                  o_pulse_updated;
    logic                  o_direction_level;
    logic                  o_motor_enabled;
    logic                  o_ping_reply;
    logic                  o_command_rejected;
    logic                  o_ramping;

    // Shadow registers
    logic [CMD_W-1:0]  lim_max  = MAX_CMD_RST;
    logic [CMD_W-1:0]  lim_min  = MIN_CMD_RST;
    logic [CMD_W-1:0]  zero_cmd = OFFSET_RST;
    logic [STEP_W-1:0] freq_inc = FREQ_STEP_RST;
    logic [CLK_W-1:0]  timer_hz = CNT_CLK_RST;
    logic [NUM_W-1:0]  fin_num  = FINAL_NUM_RST;

    // Shadow ramp state
    logic [CMD_W-1:0]      tgt_mag    = '0;
    logic [FREQ_W-1:0]     cur_freq   = '0;
    logic [CMD_W-1:0]      ticks_left = '0;
    logic                  ramp_up    = 1'b0;
    logic                  fin_pend   = 1'b0;
    logic                  dir_fwd    = 1'b1;
    logic                  drv_en     = 1'b0;
    logic [PULSE_BITS-1:0] cmp_val    = '0;

    t_ramp_result results_due[$];
    t_script_row  script[$];

    int idle_pct = 22;
    int failures = 0;
    int stall_cycles = 0;
    int n_in = 0, n_out = 0, n_loads = 0, n_pings = 0, n_rejects = 0, n_writes = 0;

    stepper_speed_command_ramp dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_mode             (i_mode),
        .i_command_byte     (i_command_byte),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_pulse_value      (o_pulse_value),
        .o_pulse_updated    (o_pulse_updated),
        .o_direction_level  (o_direction_level),
        .o_motor_enabled    (o_motor_enabled),
        .o_ping_reply       (o_ping_reply),
        .o_command_rejected (o_command_rejected),
        .o_ramping          (o_ramping)
    );

    always #10 i_clk = ~i_clk;

    // Compare value saturates at the pulse width
    function automatic logic [PULSE_BITS-1:0] clip_pulse(input logic [63:0] v);
        if ((v >> PULSE_BITS) != 0) return '1;
        return v[PULSE_BITS-1:0];
    endfunction

    function automatic bit ramp_pending();
        return (ticks_left != 0) || fin_pend;
    endfunction

    // Speed ramp predictor: advances the shadow state by one input transaction
    function automatic t_ramp_result advance_ramp(input logic mode, input logic [CMD_W-1:0] cmd);
        t_ramp_result r;
        logic [CMD_W-1:0]  mag;
        logic [FREQ_W:0]   sum;
        logic [63:0]       num_w;
        logic [63:0]       den_w;
        r = '0;
        if (mode == 1'b0) begin
            if (ramp_pending()) begin
                r.rej = 1'b1;
            end else if (cmd == PING_BYTE) begin
                r.ping = 1'b1;
            end else if (cmd > lim_max || cmd < lim_min) begin
                r.rej = 1'b1;
            end else begin
                // direction split around the zero-speed byte
                if (cmd < zero_cmd) begin
                    mag = zero_cmd - cmd;
                    dir_fwd = 1'b0;
                end else begin
                    mag = cmd - zero_cmd;
                    if (mag != 0) dir_fwd = 1'b1;
                end
                if (mag > tgt_mag) begin
                    drv_en = 1'b1;
                    ramp_up = 1'b1;
                    ticks_left = mag - tgt_mag;
                    fin_pend = 1'b1;
                end else if (mag < tgt_mag) begin
                    ramp_up = 1'b0;
                    ticks_left = tgt_mag - mag;
                    fin_pend = 1'b1;
                end
                tgt_mag = mag;
            end
        end else if (ticks_left != 0) begin
            // one ramp step, frequency saturates both ways
            if (ramp_up) begin
                sum = (FREQ_W+1)'(cur_freq) + (FREQ_W+1)'(freq_inc);
                cur_freq = (sum > FREQ_MAX) ? FREQ_MAX : sum[FREQ_W-1:0];
            end else begin
                cur_freq = (cur_freq < FREQ_W'(freq_inc)) ? '0 : cur_freq - FREQ_W'(freq_inc);
            end
            if (cur_freq == 0) begin
                cmp_val = '0;
            end else begin
                num_w = 64'(timer_hz);
                den_w = 64'(cur_freq);
                den_w = den_w << 1;
                cmp_val = clip_pulse(num_w / den_w);
            end
            ticks_left = ticks_left - 1'b1;
            r.upd = 1'b1;
        end else if (fin_pend) begin
            // final load, rounded half up
            if (tgt_mag == 0) begin
                cmp_val = '0;
            end else begin
                num_w = 64'(fin_num);
                num_w = (num_w << 1) + 64'(tgt_mag);
                den_w = 64'(tgt_mag);
                den_w = den_w << 1;
                cmp_val = clip_pulse(num_w / den_w);
            end
            if (!ramp_up && tgt_mag == 0) drv_en = 1'b0;
            fin_pend = 1'b0;
            r.upd = 1'b1;
        end
        r.pulse = cmp_val;
        r.dir   = dir_fwd;
        r.en    = drv_en;
        r.busy  = ramp_pending();
        return r;
    endfunction

    function automatic t_script_row item_row(input logic mode, input logic [CMD_W-1:0] cmd,
                                             input bit typed, input t_ramp_result shown);
        t_script_row row;
        row = '0;
        row.kind  = ROW_ITEM;
        row.mode  = mode;
        row.cmd   = cmd;
        row.typed = typed;
        row.shown = shown;
        return row;
    endfunction

    function automatic t_script_row cfg_row(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        t_script_row row;
        row = '0;
        row.kind = ROW_CFG;
        row.idx  = idx;
        row.data = data;
        return row;
    endfunction

    // Send one input transaction; prediction is taken at acceptance
    task automatic send_item(input logic mode, input logic [CMD_W-1:0] cmd,
                             input bit typed, input t_ramp_result shown);
        t_ramp_result r;
        if ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < 60);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= mode;
        i_command_byte <= cmd;
        do @(posedge i_clk); while (!o_in_ready);
        r = advance_ramp(mode, cmd);
        results_due.push_back(typed ? shown : r);
        n_in++;
        n_loads   += r.upd;
        n_pings   += r.ping;
        n_rejects += r.rej;
    endtask

    // Hold off input until every predicted result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_register(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        drain_results();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MAX_CMD:   lim_max  = value[CMD_W-1:0];
            CFG_MIN_CMD:   lim_min  = value[CMD_W-1:0];
            CFG_OFFSET:    zero_cmd = value[CMD_W-1:0];
            CFG_FREQ_STEP: freq_inc = value[STEP_W-1:0];
            CFG_CNT_CLK:   timer_hz = value[CLK_W-1:0];
            CFG_FINAL_NUM: fin_num  = value[NUM_W-1:0];
            default: ;
        endcase
        n_writes++;
    endtask

    task automatic load_settings(input logic [CMD_W-1:0] mx, input logic [CMD_W-1:0] mn,
                                 input logic [CMD_W-1:0] off, input logic [STEP_W-1:0] stp,
                                 input logic [CLK_W-1:0] hz, input logic [NUM_W-1:0] num);
        set_register(CFG_MAX_CMD, CFG_W'(mx));
        set_register(CFG_MIN_CMD, CFG_W'(mn));
        set_register(CFG_OFFSET, CFG_W'(off));
        set_register(CFG_FREQ_STEP, CFG_W'(stp));
        set_register(CFG_CNT_CLK, CFG_W'(hz));
        set_register(CFG_FINAL_NUM, CFG_W'(num));
    endtask

    // Finish any pending ramp, issue a speed command, then tick until the
    // ramp and final load are done
    task automatic ramp_to(input logic [CMD_W-1:0] cmd);
        while (ramp_pending()) send_item(1'b1, CMD_W'($urandom), 1'b0, '0);
        send_item(1'b0, cmd, 1'b0, '0);
        while (ramp_pending()) send_item(1'b1, CMD_W'($urandom), 1'b0, '0);
    endtask

    // Output side: random backpressure and check against the oldest prediction
    always @(posedge i_clk) begin
        t_ramp_result act, exp_r;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                act = '{o_pulse_value, o_pulse_updated, o_direction_level, o_motor_enabled,
                        o_ping_reply, o_command_rejected, o_ramping};
                n_out++;
                if (results_due.size() == 0) begin
                    failures++;
                    if (failures <= SHOW_LIMIT)
                        $display("unexpected result transaction: pulse %0d", act.pulse);
                end else begin
                    exp_r = results_due.pop_front();
                    if (act !== exp_r) begin
                        failures++;
                        if (failures <= SHOW_LIMIT)
                            $display("result %0d mismatch (exp/act): pulse %0d/%0d upd %b/%b ",
                                     n_out, exp_r.pulse, act.pulse, exp_r.upd, act.upd,
                                     "dir %b/%b en %b/%b ping %b/%b rej %b/%b ramping %b/%b",
                                     exp_r.dir, act.dir, exp_r.en, act.en, exp_r.ping,
                                     act.ping, exp_r.rej, act.rej, exp_r.busy, act.busy);
                    end
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("stepper_speed_command_ramp verification failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        t_script_row       row;
        int                phase, n, pick, v;
        logic              mode;
        logic [CMD_W-1:0]  cmd;
        logic [CMD_W-1:0]  mx, mn, off;
        logic [STEP_W-1:0] stp;
        logic [CLK_W-1:0]  hz;
        logic [NUM_W-1:0]  num;

        // Directed table; typed results are {pulse, upd, dir, en, ping, rej, ramping}
        script.push_back(item_row(1'b1, 8'h00, 1'b1, '{32'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}));
        script.push_back(item_row(1'b0, 8'hFF, 1'b1, '{32'd0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0}));
        script.push_back(item_row(1'b0, 8'd127, 1'b1, '{32'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}));
        script.push_back(item_row(1'b0, 8'd130, 1'b0, '0));
        // commands during a ramp, a ping among them, bounce off
        script.push_back(item_row(1'b0, 8'h00, 1'b1, '{32'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1}));
        script.push_back(item_row(1'b0, 8'hFF, 1'b1, '{32'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1}));
        repeat (4) script.push_back(item_row(1'b1, 8'h00, 1'b0, '0));
        // reverse, smaller magnitude: downward ramp
        script.push_back(item_row(1'b0, 8'd126, 1'b0, '0));
        repeat (3) script.push_back(item_row(1'b1, 8'h5A, 1'b0, '0));
        // zero target keeps reverse, frequency reaches 0, driver drops at the end
        script.push_back(item_row(1'b0, 8'd127, 1'b0, '0));
        script.push_back(item_row(1'b1, 8'hA5, 1'b0, '0));
        script.push_back(item_row(1'b1, 8'h00, 1'b1, '{32'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}));
        // limits
        script.push_back(cfg_row(CFG_MAX_CMD, 40'd200));
        script.push_back(cfg_row(CFG_MIN_CMD, 40'd50));
        script.push_back(item_row(1'b0, 8'd201, 1'b1, '{32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}));
        script.push_back(item_row(1'b0, 8'd49, 1'b1, '{32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}));
        // extreme settings: largest step, clock and numerator, zero offset
        script.push_back(cfg_row(CFG_OFFSET, 40'd0));
        script.push_back(cfg_row(CFG_MAX_CMD, 40'd255));
        script.push_back(cfg_row(CFG_MIN_CMD, 40'd0));
        script.push_back(cfg_row(CFG_FREQ_STEP, 40'hFFFF));
        script.push_back(cfg_row(CFG_CNT_CLK, 40'hFFFF_FFFF));
        script.push_back(cfg_row(CFG_FINAL_NUM, 40'hFF_FFFF_FFFF));
        script.push_back(item_row(1'b0, 8'd2, 1'b0, '0));
        repeat (2) script.push_back(item_row(1'b1, 8'hFF, 1'b0, '0));
        script.push_back(item_row(1'b1, 8'h00, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}));
        // ping still wins with max_command at 255
        script.push_back(item_row(1'b0, 8'hFF, 1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[k]) begin
            row = script[k];
            if (row.kind == ROW_CFG) set_register(row.idx, row.data);
            else send_item(row.mode, row.cmd, row.typed, row.shown);
        end

        // Random phases, each with its own register settings
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            idle_pct = (phase == 2) ? 0 : 22;
            mx  = CMD_W'($urandom_range(180, 254));
            mn  = CMD_W'($urandom_range(0, 60));
            off = CMD_W'($urandom_range(mn + 20, mx - 20));
            stp = STEP_W'($urandom_range(1, 3000));
            hz  = $urandom;
            if (hz == 0) hz = 1;
            num = NUM_W'($urandom);
            case (phase)
                1: begin
                    stp = '0;
                    hz  = 1;
                    num = '0;
                end
                2: mx = 8'd255;
                3: begin
                    mx  = CMD_W'($urandom);
                    mn  = CMD_W'($urandom);
                    off = CMD_W'($urandom);
                end
                4: begin
                    stp = '1;
                    hz  = '1;
                    num = NUM_W'({$urandom, $urandom});
                end
                5: begin
                    off = '0;
                    mn  = '0;
                end
                default: ;
            endcase
            load_settings(mx, mn, off, stp, hz, num);

            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 0 && n == PHASE_ITEMS / 2) drain_results();
                pick = $urandom_range(0, 99);
                mode = 1'b0;
                cmd  = CMD_W'($urandom);
                if (ramp_pending()) begin
                    // mostly ticks; the rest are commands that must bounce
                    if (pick < 85) mode = 1'b1;
                    else if (pick >= 95) cmd = PING_BYTE;
                end else if (pick < 60) begin
                    v = zero_cmd + $urandom_range(0, 16) - 8;
                    if (v < 0) v = 0;
                    if (v > 255) v = 255;
                    cmd = v[CMD_W-1:0];
                end else if (pick < 63) begin
                    if (lim_min <= lim_max) cmd = CMD_W'($urandom_range(lim_min, lim_max));
                end else if (pick < 73) begin
                    cmd = PING_BYTE;
                end else if (pick >= 85) begin
                    mode = 1'b1;
                end
                send_item(mode, cmd, 1'b0, '0);
            end
        end

        // Drive the frequency into its upper limit: climb with the full step,
        // come down a little with a zero step, then climb again
        idle_pct = 22;
        load_settings(8'd254, 8'd0, 8'd255, 16'd0, $urandom | 1, NUM_W'($urandom));
        ramp_to(8'd254);
        set_register(CFG_FREQ_STEP, 40'hFFFF);
        ramp_to(8'd0);
        set_register(CFG_FREQ_STEP, 40'd0);
        ramp_to(8'd8);
        set_register(CFG_FREQ_STEP, 40'hFFFF);
        ramp_to(8'd0);

        drain_results();
        repeat (SETTLE_WAIT) @(posedge i_clk);

        $display("Run covered %0d transactions in, %0d out: %0d compare loads, %0d pings, ",
                 n_in, n_out, n_loads, n_pings, "%0d rejected commands, %0d register writes",
                 n_rejects, n_writes);
        if (failures == 0 && results_due.size() == 0) begin
            $display("stepper_speed_command_ramp verification clean");
        end else begin
            $display("%0d failures, %0d results missing", failures, results_due.size());
            $display("stepper_speed_command_ramp verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/sscr_pkg.sv
design/sscr_div.sv
design/stepper_speed_command_ramp.sv
design/sscr_checker.sv
sim/stepper_speed_command_ramp_test.sv
